[rtl/csem_pkg.sv]
// Shared types and constants for the counting semaphore with FIFO wait queue.
// Request and response structs, operation, status and register codes.
// No dependencies.
`default_nettype none

package csem_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int REQ_ID_W = 16;
    localparam int STATUS_W = 3;
    localparam int UNITS_W  = 16;
    localparam int WAIT_W   = 5;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACQ = 2'd0;
    localparam logic [OP_W-1:0] OP_REL = 2'd1;
    localparam logic [OP_W-1:0] OP_TRY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_AT_MAX  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_MAX_UNITS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_INIT_UNITS = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_INVALID_ID = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     req_type;
        logic [REQ_ID_W-1:0] requester_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [UNITS_W-1:0]  units_free;
        logic [WAIT_W-1:0]   waiters;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/counting_semaphore_fifo_wait.sv]
// Top level of the counting semaphore with FIFO wait queue.
// Depends on csem_pkg and csem_ram (wait queue storage).
//
// Usage:
//   request channel: drive i_req and raise start; a request is taken at a
//   clock edge where start is high and busy is low.
//   response: o_rsp is shown for exactly one cycle with o_rsp_strobe high,
//   one response per request; the receiver cannot stall it.
//   configuration: i_cfg_addr / i_cfg_data with i_cfg_valid, taken when
//   o_cfg_ready is high (no request in work and start low).
// Timing:
//   release, try-acquire, refused requests and acquires that find a free
//   unit or an empty queue answer in the cycle after the request; busy stays low.
//   an acquire on a zero count with waiters queued scans the queue for a
//   duplicate through the single RAM read port and one ID comparator, one
//   entry per cycle; busy stays high until a duplicate turns up or every
//   queued entry has been compared, and the response follows in the cycle
//   after the scan ends.
// Reset: max_units 1, count 0, queue empty, invalid_id 0; no clearing pass.
`default_nettype none

module counting_semaphore_fifo_wait #(
    parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = csem_pkg::ID_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire csem_pkg::t_req              i_req,
    output logic                             o_rsp_strobe,
    output csem_pkg::t_rsp                   o_rsp,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [csem_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [csem_pkg::CFG_D_W-1:0] i_cfg_data
);

    import csem_pkg::*;

    // stored id width, index width, fill width
    localparam int SW = (ID_WIDTH < REQ_ID_W) ? ID_WIDTH : REQ_ID_W;
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [UNITS_W-1:0] r_count, n_count;
    logic [UNITS_W-1:0] r_max, n_max;
    logic [CFG_D_W-1:0] r_inv, n_inv;
    logic [IW-1:0]      r_head, n_head;
    logic [FW-1:0]      r_fill, n_fill;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic [FW-1:0]      r_cnt, n_cnt;
    logic               r_rd_vld, n_rd_vld;
    logic [SW-1:0]      r_id, n_id;
    logic               r_strobe, n_strobe;
    t_rsp               r_rsp, n_rsp;

    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [SW-1:0]      ram_rdata;
    logic [IW-1:0]      tail;
    logic [FW:0]        tail_sum;
    logic [SW-1:0]      id_in;
    logic               hit;
    logic               cfg_fire;

    // advance a ring index with wrap
    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] p);
        logic [IW-1:0] q;
        if (p == IW'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + IW'(1);
        end
        return q;
    endfunction

    // tail slot: head + fill, wrapped with one subtract
    always_comb begin
        tail_sum = (FW+1)'(r_head) + (FW+1)'(r_fill);
        if (tail_sum >= (FW+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (FW+1)'(QUEUE_DEPTH);
        end
        tail = tail_sum[IW-1:0];
    end

    assign id_in    = i_req.requester_id[SW-1:0];
    assign hit      = r_rd_vld && (ram_rdata == r_id);
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    // sequencer and semaphore state
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_max     = r_max;
        n_inv     = r_inv;
        n_head    = r_head;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_rd_vld  = 1'b0;
        n_id      = r_id;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    unique case (i_cfg_addr)
                        REG_MAX_UNITS: begin
                            n_max = (i_cfg_data == '0) ? UNITS_W'(1) : i_cfg_data;
                        end
                        REG_INIT_UNITS: begin
                            n_count = (i_cfg_data < r_max) ? i_cfg_data : r_max;
                            n_head  = '0;
                            n_fill  = '0;
                        end
                        REG_INVALID_ID: begin
                            n_inv = i_cfg_data;
                        end
                        default: begin
                        end
                    endcase
                end else if (start) begin
                    n_id         = id_in;
                    n_strobe     = 1'b1;
                    n_rsp.status = ST_OK;
                    if (id_in == r_inv[SW-1:0]) begin
                        n_rsp.status = ST_INVALID;
                    end else begin
                        unique case (i_req.req_type)
                            OP_ACQ: begin
                                if (r_count != '0) begin
                                    n_count = r_count - UNITS_W'(1);
                                end else if (r_fill == '0) begin
                                    // empty queue: no duplicate possible
                                    ram_we       = 1'b1;
                                    n_fill       = FW'(1);
                                    n_rsp.status = ST_BUSY;
                                end else begin
                                    // duplicate scan over the queued waiters
                                    n_strobe = 1'b0;
                                    n_state  = S_SCAN;
                                    n_ptr    = r_head;
                                    n_cnt    = '0;
                                end
                            end
                            OP_REL: begin
                                if (r_fill != '0) begin
                                    n_head = f_next(r_head);
                                    n_fill = r_fill - FW'(1);
                                end else if (r_count >= r_max) begin
                                    n_rsp.status = ST_AT_MAX;
                                end else begin
                                    n_count = r_count + UNITS_W'(1);
                                end
                            end
                            OP_TRY: begin
                                if (r_count == '0) begin
                                    n_rsp.status = ST_BUSY;
                                end else begin
                                    n_count = r_count - UNITS_W'(1);
                                end
                            end
                            default: begin
                                n_rsp.status = ST_INVALID;
                            end
                        endcase
                    end
                    n_rsp.units_free = n_count;
                    n_rsp.waiters    = WAIT_W'(n_fill);
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // requester already waiting
                    n_state      = S_IDLE;
                    n_strobe     = 1'b1;
                    n_rsp.status = ST_BUSY;
                end else if (r_cnt == r_fill) begin
                    // all entries compared without a match
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_fill >= FW'(QUEUE_DEPTH)) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        ram_we       = 1'b1;
                        n_fill       = r_fill + FW'(1);
                        n_rsp.status = ST_BUSY;
                    end
                end else begin
                    // issue the next read
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_ptr    = f_next(r_ptr);
                    n_cnt    = r_cnt + FW'(1);
                end
                n_rsp.units_free = r_count;
                n_rsp.waiters    = WAIT_W'(n_fill);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_max    <= UNITS_W'(1);
            r_inv    <= '0;
            r_head   <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_max    <= n_max;
            r_inv    <= n_inv;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_cnt <= n_cnt;
        r_id  <= n_id;
        r_rsp <= n_rsp;
    end

    // wait queue storage
    csem_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (n_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a request being started takes the idle slot ahead of a register write
    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE) && !start;
    assign o_rsp_strobe = r_strobe;
    assign o_rsp        = r_rsp;

endmodule

`default_nettype wire

[rtl/csem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on csem_pkg for default sizes only.
`default_nettype none

module csem_ram #(
    parameter int WIDTH = csem_pkg::ID_WIDTH_DEF,
    parameter int DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[tb/tb_counting_semaphore_fifo_wait.sv]
// Self-checking testbench for the counting semaphore with FIFO wait queue.
// Drives requests and register writes, predicts every response and checks it.
// Depends on csem_pkg and the counting_semaphore_fifo_wait top level.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_wait;

    import csem_pkg::*;

    localparam int               RING_DEPTH   = QUEUE_DEPTH_DEF;
    localparam int               SLOT_W       = $clog2(RING_DEPTH);
    localparam int               EXP_DEPTH    = 8;
    localparam int               SETTLE_CYCLES = 20;
    localparam int               QUIET_LIMIT  = 2000;
    localparam int               RAND_PHASES  = 7;
    localparam int               PHASE_ITEMS  = 200;
    // request type the block does not know
    localparam logic [OP_W-1:0]  OP_BAD       = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_rsp_strobe;
    t_rsp                 o_rsp;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_A_W-1:0]   i_cfg_addr = '0;
    logic [CFG_D_W-1:0]   i_cfg_data = '0;

    // shadow of the semaphore state
    logic [UNITS_W-1:0]   sem_max_units;
    logic [UNITS_W-1:0]   sem_units;
    logic [REQ_ID_W-1:0]  sem_invalid_id;
    logic [REQ_ID_W-1:0]  sem_ring [RING_DEPTH];
    logic [SLOT_W-1:0]    sem_head;
    logic [WAIT_W-1:0]    sem_fill;

    // expected responses in request order
    t_rsp                 exp_fifo [EXP_DEPTH];
    int unsigned          exp_wr = 0;
    int unsigned          exp_rd = 0;
    int                   n_errors = 0;
    int unsigned          quiet_cycles = 0;

    // random traffic shape of the current phase
    logic [REQ_ID_W-1:0]  id_base;
    int                   id_pool;
    int                   acq_weight;
    bit                   no_idle;

    counting_semaphore_fifo_wait u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_rsp_strobe (o_rsp_strobe),
        .o_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state after reset
    initial begin
        sem_max_units  = UNITS_W'(1);
        sem_units      = '0;
        sem_invalid_id = '0;
        sem_head       = '0;
        sem_fill       = '0;
    end

    function automatic bit id_is_waiting(logic [REQ_ID_W-1:0] id);
        for (int k = 0; k < int'(sem_fill); k++) begin
            if (sem_ring[SLOT_W'((int'(sem_head) + k) % RING_DEPTH)] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    // queue one expected response
    function automatic void exp_store(t_rsp rsp);
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
            $error("expected response store overflow");
            n_errors++;
        end
        exp_fifo[exp_wr % EXP_DEPTH] = rsp;
        exp_wr++;
    endfunction

    // apply one request to the shadow state and return its response
    task automatic predict_grant(input t_req r, output t_rsp rsp);
        logic [STATUS_W-1:0] st;
        st = ST_OK;
        if (r.requester_id == sem_invalid_id || r.req_type == OP_BAD) begin
            st = ST_INVALID;
        end else if (r.req_type == OP_ACQ) begin
            if (sem_units > 0) begin
                sem_units = sem_units - UNITS_W'(1);
            end else if (id_is_waiting(r.requester_id)) begin
                st = ST_BUSY;
            end else if (sem_fill >= WAIT_W'(RING_DEPTH)) begin
                st = ST_FULL;
            end else begin
                sem_ring[SLOT_W'((int'(sem_head) + int'(sem_fill)) % RING_DEPTH)] =
                    r.requester_id;
                sem_fill = sem_fill + WAIT_W'(1);
                st = ST_BUSY;
            end
        end else if (r.req_type == OP_REL) begin
            if (sem_fill > 0) begin
                sem_head = SLOT_W'((int'(sem_head) + 1) % RING_DEPTH);
                sem_fill = sem_fill - WAIT_W'(1);
            end else if (sem_units >= sem_max_units) begin
                st = ST_AT_MAX;
            end else begin
                sem_units = sem_units + UNITS_W'(1);
            end
        end else begin
            if (sem_units == 0) st = ST_BUSY;
            else sem_units = sem_units - UNITS_W'(1);
        end
        rsp.status     = st;
        rsp.units_free = sem_units;
        rsp.waiters    = sem_fill;
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_strobe) begin
            if (exp_wr == exp_rd) begin
                $error("response with no request outstanding: status %0d units %0d waiters %0d",
                       o_rsp.status, o_rsp.units_free, o_rsp.waiters);
                n_errors++;
            end else begin
                t_rsp exp_rsp;
                exp_rsp = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status expected %0d actual %0d", exp_rsp.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.units_free !== exp_rsp.units_free) begin
                    $error("units_free expected %0d actual %0d",
                           exp_rsp.units_free, o_rsp.units_free);
                    n_errors++;
                end
                if (o_rsp.waiters !== exp_rsp.waiters) begin
                    $error("waiters expected %0d actual %0d", exp_rsp.waiters, o_rsp.waiters);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_rsp_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one request; start stays high when gap is zero
    task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_ID_W-1:0] id,
                                input int gap);
        t_req r;
        t_rsp rsp;
        r.req_type     = op;
        r.requester_id = id;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predict_grant(r, rsp);
        exp_store(rsp);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop requesting and wait for every response plus scan latency
    task automatic settle();
        start <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_UNITS: sem_max_units = (val == 0) ? UNITS_W'(1) : val;
            REG_INIT_UNITS: begin
                sem_units = (val < sem_max_units) ? val : sem_max_units;
                sem_head  = '0;
                sem_fill  = '0;
            end
            REG_INVALID_ID: sem_invalid_id = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // defaults after reset: max 1, count 0, id 0 refused
    task automatic test_reset_state();
        send_request(OP_REL, 16'd0, 0);
        send_request(OP_TRY, 16'd1, 1);
        send_request(OP_REL, 16'd1, 0);
        send_request(OP_REL, 16'd2, 2);
        send_request(OP_ACQ, 16'd3, 0);
    endtask

    // fill the wait queue, duplicate waiter, full queue, refused requests
    task automatic test_queue_limits();
        write_register(REG_MAX_UNITS, 16'hFFFF);
        write_register(REG_INIT_UNITS, 16'd0);
        write_register(REG_INVALID_ID, 16'hFFFF);
        for (int k = 0; k < RING_DEPTH; k++) send_request(OP_ACQ, k[REQ_ID_W-1:0], pick_gap());
        send_request(OP_ACQ, 16'd0, 0);
        send_request(OP_ACQ, 16'hFFFE, 0);
        send_request(OP_ACQ, 16'hFFFF, 1);
        send_request(OP_REL, 16'h1234, 0);
        send_request(OP_BAD, 16'h0042, 0);
    endtask

    // release at maximum, clamping of the initial count, maximum written as zero
    task automatic test_release_rules();
        write_register(REG_INIT_UNITS, 16'hFFFF);
        send_request(OP_REL, 16'h00A5, 0);
        send_request(OP_TRY, 16'h5A00, 0);
        write_register(REG_MAX_UNITS, 16'd0);
        write_register(REG_INIT_UNITS, 16'hFFFF);
        send_request(OP_REL, 16'h0001, 0);
        send_request(OP_TRY, 16'h0001, 0);
        send_request(OP_TRY, 16'h0002, 0);
    endtask

    // lowering the maximum leaves a larger count in place
    task automatic test_lower_max();
        write_register(REG_MAX_UNITS, 16'd10);
        write_register(REG_INIT_UNITS, 16'd5);
        write_register(REG_MAX_UNITS, 16'd2);
        send_request(OP_REL, 16'h0003, 0);
        send_request(OP_TRY, 16'h0003, 0);
    endtask

    // sender holds off until every response has arrived
    task automatic test_hold_off();
        send_request(OP_ACQ, 16'h0010, 0);
        send_request(OP_ACQ, 16'h0011, 0);
        settle();
        send_request(OP_REL, 16'h0012, 0);
        send_request(OP_REL, 16'h0013, 1);
    endtask

    task automatic pick_setting();
        logic [CFG_D_W-1:0] max_val;
        logic [CFG_D_W-1:0] init_val;
        logic [CFG_D_W-1:0] bad_id;
        int                 lim;
        case ($urandom_range(0, 9))
            0: max_val = 16'd0;
            1: max_val = 16'hFFFF;
            2: max_val = CFG_D_W'($urandom_range(0, 65535));
            default: max_val = CFG_D_W'($urandom_range(1, 4));
        endcase
        lim = (max_val == 0) ? 1 : int'(max_val);
        case ($urandom_range(0, 9))
            0: init_val = 16'hFFFF;
            1: init_val = 16'd0;
            2: init_val = CFG_D_W'($urandom_range(0, 65535));
            default: init_val = CFG_D_W'($urandom_range(0, (lim > 65534) ? 65535 : lim + 1));
        endcase
        id_base    = REQ_ID_W'($urandom_range(0, 65535 - 32));
        id_pool    = $urandom_range(4, 24);
        acq_weight = $urandom_range(35, 65);
        no_idle    = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1)) begin
            bad_id = CFG_D_W'(int'(id_base) + int'($urandom_range(0, id_pool - 1)));
        end else begin
            bad_id = CFG_D_W'($urandom_range(0, 65535));
        end
        write_register(REG_MAX_UNITS, max_val);
        write_register(REG_INIT_UNITS, init_val);
        write_register(REG_INVALID_ID, bad_id);
    endtask

    // random traffic from a small id pool so counts run dry and the queue fills
    task automatic test_random_traffic();
        logic [OP_W-1:0]     op;
        logic [REQ_ID_W-1:0] id;
        int                  r;
        for (int p = 0; p < RAND_PHASES; p++) begin
            pick_setting();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < acq_weight) op = OP_ACQ;
                else if (r < acq_weight + (95 - acq_weight) * 2 / 3) op = OP_REL;
                else if (r < 95) op = OP_TRY;
                else op = OP_BAD;
                r = $urandom_range(0, 99);
                if (r < 8) id = REQ_ID_W'($urandom_range(0, 65535));
                else if (r < 12) id = sem_invalid_id;
                else id = REQ_ID_W'(int'(id_base) + int'($urandom_range(0, id_pool - 1)));
                send_request(op, id, pick_gap());
            end
        end
    endtask

    initial begin
        no_idle = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_queue_limits();
        test_release_rules();
        test_lower_max();
        test_hold_off();
        test_random_traffic();
        settle();
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/csem_pkg.sv
rtl/csem_ram.sv
rtl/counting_semaphore_fifo_wait.sv
tb/tb_counting_semaphore_fifo_wait.sv
